[design/ps2mct_pkg.sv]
// Package for the PS/2 mouse packet cursor tracker.
// Holds the shared types, register indexes, field widths and reset values.
// No dependencies.
package ps2mct_pkg;

  localparam int unsigned DimW     = 10;
  localparam int unsigned BtnW     = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  // result packing, lowest bit first
  localparam int unsigned ColLsb    = 0;
  localparam int unsigned RowLsb    = 10;
  localparam int unsigned BtnLsb    = 20;
  localparam int unsigned MovedBit  = 23;
  localparam int unsigned ScrUpBit  = 24;
  localparam int unsigned ScrDnBit  = 25;
  localparam int unsigned UsedBits  = 26;

  localparam logic [DimW-1:0] ColsRst = 10'd80;
  localparam logic [DimW-1:0] RowsRst = 10'd25;
  localparam logic [DimW-1:0] ColRst  = 10'd40;
  localparam logic [DimW-1:0] RowRst  = 10'd12;

  // flag byte bits
  localparam int unsigned XSignBit = 4;
  localparam int unsigned YSignBit = 5;
  localparam int unsigned XOvfBit  = 6;
  localparam int unsigned YOvfBit  = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_ROWS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_FLAGS = 2'd0,
    PH_DX    = 2'd1,
    PH_DY    = 2'd2
  } pkt_phase_e;

  typedef struct packed {
    logic            scroll_down;
    logic            scroll_up;
    logic            moved;
    logic [BtnW-1:0] button_bits;
    logic [DimW-1:0] cursor_row;
    logic [DimW-1:0] cursor_col;
  } result_t;

  // screen size of zero behaves as one
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] d);
    eff_dim = (d == '0) ? DimW'(1) : d;
  endfunction

  // 9-bit movement with overflow forcing, returned as 10-bit signed
  function automatic logic signed [DimW-1:0] movement(input logic [ByteW-1:0] low,
                                                      input logic neg,
                                                      input logic ovf);
    if (ovf) begin
      movement = neg ? -10'sd256 : 10'sd256;
    end else begin
      movement = $signed({neg, neg, low});
    end
  endfunction

endpackage

[design/ps2_mouse_packet_cursor_tracker_unit.sv]
// PS/2 mouse packet cursor tracker: 3-byte packet assembly, cursor clamp, scroll events.
// Depends on ps2mct_pkg.
// Output: the result is registered and appears on the master side in the cycle after the third byte is accepted.
// Throughput: one byte per cycle; input stalls only while a result waits on a stalled master.
// Reset (async, active low): disabled, 80x25 screen, cursor at 40/12, packet phase cleared.
module ps2_mouse_packet_cursor_tracker_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ps2mct_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ps2mct_pkg::DimW-1:0]      cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ps2mct_pkg::InDataW-1:0]   s_axis_tdata,  // [7:0] rx_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] cursor_col, [19:10] cursor_row, [22:20] button_bits, [23] moved,
  // [24] scroll_up, [25] scroll_down, [31:26] zero
  output logic [ps2mct_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned DimW = ps2mct_pkg::DimW;
  localparam int unsigned SumW = DimW + 2;

  logic                          enable_q, enable_d;
  logic [DimW-1:0]               cols_q, cols_d;
  logic [DimW-1:0]               rows_q, rows_d;
  ps2mct_pkg::pkt_phase_e        phase_q, phase_d;
  logic [ps2mct_pkg::ByteW-1:0]  flag_q, flag_d;
  logic [ps2mct_pkg::ByteW-1:0]  dx_q, dx_d;
  logic [DimW-1:0]               col_q, col_d;
  logic [DimW-1:0]               row_q, row_d;
  logic [ps2mct_pkg::BtnW-1:0]   btn_q, btn_d;
  logic                          out_valid_q, out_valid_d;
  ps2mct_pkg::result_t           res_q, res_d;

  logic                          in_acc;
  logic                          cfg_hit;
  logic                          res_load;
  logic [DimW-1:0]               cols_eff, rows_eff;
  logic [DimW-1:0]               hold_cols, hold_rows;
  logic signed [DimW-1:0]        dx, dy;
  logic signed [SumW-1:0]        nx, ny;
  logic [DimW-1:0]               nx_clamp, ny_clamp;
  logic                          any_move, sdown, sup;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(ps2mct_pkg::OutDataW - ps2mct_pkg::UsedBits)'(0), res_q};

  assign cols_eff = ps2mct_pkg::eff_dim(cols_q);
  assign rows_eff = ps2mct_pkg::eff_dim(rows_q);

  // movement and clamp for the third byte
  always_comb begin
    dx = ps2mct_pkg::movement(dx_q, flag_q[ps2mct_pkg::XSignBit], flag_q[ps2mct_pkg::XOvfBit]);
    dy = ps2mct_pkg::movement(s_axis_tdata, flag_q[ps2mct_pkg::YSignBit],
                              flag_q[ps2mct_pkg::YOvfBit]);
    any_move = (dx != '0) || (dy != '0);
    nx = $signed({2'b00, col_q}) + $signed({{2{dx[DimW-1]}}, dx});
    ny = $signed({2'b00, row_q}) - $signed({{2{dy[DimW-1]}}, dy});
    sdown = 1'b0;
    sup   = 1'b0;
    if (ny < 0) begin
      sdown    = 1'b1;
      ny_clamp = '0;
    end else if (ny >= $signed({2'b00, rows_eff})) begin
      sup      = 1'b1;
      ny_clamp = rows_eff - DimW'(1);
    end else begin
      ny_clamp = ny[DimW-1:0];
    end
    if (nx < 0) begin
      nx_clamp = '0;
    end else if (nx >= $signed({2'b00, cols_eff})) begin
      nx_clamp = cols_eff - DimW'(1);
    end else begin
      nx_clamp = nx[DimW-1:0];
    end
  end

  always_comb begin
    enable_d    = enable_q;
    cols_d      = cols_q;
    rows_d      = rows_q;
    phase_d     = phase_q;
    flag_d      = flag_q;
    dx_d        = dx_q;
    col_d       = col_q;
    row_d       = row_q;
    btn_d       = btn_q;
    res_d       = res_q;
    res_load    = 1'b0;
    cfg_hit     = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        ps2mct_pkg::CFG_ENABLE: begin
          enable_d = cfg_data_i[0];
          cfg_hit  = 1'b1;
        end
        ps2mct_pkg::CFG_COLS: begin
          cols_d  = cfg_data_i;
          cfg_hit = 1'b1;
        end
        ps2mct_pkg::CFG_ROWS: begin
          rows_d  = cfg_data_i;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end

    hold_cols = ps2mct_pkg::eff_dim(cols_d);
    hold_rows = ps2mct_pkg::eff_dim(rows_d);

    if (cfg_hit && !enable_d) begin
      phase_d = ps2mct_pkg::PH_FLAGS;
      btn_d   = '0;
      col_d   = hold_cols >> 1;
      row_d   = hold_rows >> 1;
    end else if (!cfg_we_i && in_acc) begin
      if (!enable_q) begin
        phase_d = ps2mct_pkg::PH_FLAGS;
        btn_d   = '0;
        col_d   = cols_eff >> 1;
        row_d   = rows_eff >> 1;
      end else begin
        case (phase_q)
          ps2mct_pkg::PH_FLAGS: begin
            flag_d  = s_axis_tdata;
            phase_d = ps2mct_pkg::PH_DX;
          end
          ps2mct_pkg::PH_DX: begin
            dx_d    = s_axis_tdata;
            phase_d = ps2mct_pkg::PH_DY;
          end
          default: begin
            if (any_move) begin
              col_d = nx_clamp;
              row_d = ny_clamp;
            end
            btn_d    = flag_q[ps2mct_pkg::BtnW-1:0];
            phase_d  = ps2mct_pkg::PH_FLAGS;
            res_load = 1'b1;
            res_d.cursor_col  = any_move ? nx_clamp : col_q;
            res_d.cursor_row  = any_move ? ny_clamp : row_q;
            res_d.button_bits = flag_q[ps2mct_pkg::BtnW-1:0];
            res_d.moved       = any_move;
            res_d.scroll_up   = any_move && sup;
            res_d.scroll_down = any_move && sdown;
          end
        endcase
      end
    end

    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      cols_q      <= ps2mct_pkg::ColsRst;
      rows_q      <= ps2mct_pkg::RowsRst;
      phase_q     <= ps2mct_pkg::PH_FLAGS;
      flag_q      <= '0;
      dx_q        <= '0;
      col_q       <= ps2mct_pkg::ColRst;
      row_q       <= ps2mct_pkg::RowRst;
      btn_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      enable_q    <= enable_d;
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      phase_q     <= phase_d;
      flag_q      <= flag_d;
      dx_q        <= dx_d;
      col_q       <= col_d;
      row_q       <= row_d;
      btn_q       <= btn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

endmodule

[design/ps2mct_checker.sv]
// Port-level checker for the PS/2 mouse packet cursor tracker, with its bind.
// Depends on ps2mct_pkg and ps2_mouse_packet_cursor_tracker_unit.
module ps2mct_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid_i,
  input logic                            s_tready_i,
  input logic                            m_tvalid_i,
  input logic                            m_tready_i,
  input logic [ps2mct_pkg::OutDataW-1:0] m_tdata_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("request changed while stalled");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_i |-> s_tready_i)
    else $error("input stalled with empty output register");

  a_scroll_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> !(m_tdata_i[ps2mct_pkg::ScrUpBit] && m_tdata_i[ps2mct_pkg::ScrDnBit]))
    else $error("both scroll events set");

  a_scroll_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tdata_i[ps2mct_pkg::ScrUpBit] || m_tdata_i[ps2mct_pkg::ScrDnBit])
    |-> m_tdata_i[ps2mct_pkg::MovedBit])
    else $error("scroll without movement");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[ps2mct_pkg::OutDataW-1:ps2mct_pkg::UsedBits] == '0)
    else $error("nonzero padding in result");

endmodule

bind ps2_mouse_packet_cursor_tracker_unit ps2mct_checker u_ps2mct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);
